FILE: src/wnco_pkg.sv
// Package for the wheel next-coprime offset block.
// Holds sizes, register indexes, controller states and the control structs.
// No dependencies.
package wnco_pkg;

  localparam int MaxWheel   = 4096;
  localparam int PrimeSlots = 4;
  localparam int WBits      = 13;   // holds MaxWheel + 1
  localparam int IdxBits    = 12;   // table address
  localparam int ValBits    = 64;

  localparam logic [2:0] RegCount  = 3'd0;
  localparam logic [2:0] RegPrime0 = 3'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIZE,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_MOD,
    ST_WALK,
    ST_WALK_WAIT,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_value;
    logic size_init;
    logic size_step;
    logic scan_init;
    logic scan_step;
    logic scan_last;
    logic mod_init;
    logic mod_step;
    logic walk_init;
    logic walk_read;
    logic walk_step;
    logic finish;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic size_done;
    logic too_large;
    logic scan_done;
    logic mod_done;
    logic direct;
    logic walk_hit;
    logic walk_end;
  } stat_t;

endpackage

FILE: src/wheel_next_coprime_offset_top.sv
// Top level of the wheel next-coprime offset block.
// Depends on wnco_pkg, wnco_ctrl and wnco_datapath.
//
// Pulse start while busy is low to hand in one start_value word. The block
// returns one result word, marked by done for a single cycle; the receiver
// cannot stall it, so sample the result on that cycle. After reset or any
// register write the first word rebuilds the gap table: the prime product
// (one active slot per step) and then a scan of the table over the wheel
// (W = wheel size, at most 4096). Every word then runs the bit-serial 64-bit
// modulo and a walk over the gaps through the single-port table (up to
// phi(W) gaps). Register words are taken only while busy is low and start
// is low.
module wheel_next_coprime_offset_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] start_value,
  output logic        done,
  output logic [12:0] distance,
  output logic [11:0] gap_index,
  output logic        wheel_too_large,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  wnco_pkg::ctrl_t ctrl;
  wnco_pkg::stat_t stat;
  logic cfg_we;

  // take config words only when idle and no word is being handed in
  assign cfg_ready = !busy && !start;
  assign cfg_we    = cfg_valid && cfg_ready;

  wnco_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cfg_we(cfg_we),
    .stat(stat), .ctrl(ctrl), .busy(busy), .done(done)
  );

  wnco_datapath u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .start_value(start_value), .cfg_we(cfg_we), .cfg_idx(cfg_index),
    .cfg_data(cfg_data), .distance(distance), .gap_index(gap_index),
    .wheel_too_large(wheel_too_large)
  );

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done without busy");
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    done && wheel_too_large |-> distance == 13'd0 && gap_index == 12'd0)
    else $error("error result carries data");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after done");
`endif

endmodule

FILE: src/wnco_datapath.sv
// Datapath: wheel size product, gap table build, 64-bit modulo, gap walk.
// Depends on wnco_pkg.
module wnco_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  wnco_pkg::ctrl_t              ctrl,
  output wnco_pkg::stat_t              stat,
  input  logic [63:0]                  start_value,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_idx,
  input  logic [7:0]                   cfg_data,
  output logic [12:0]                  distance,
  output logic [11:0]                  gap_index,
  output logic                         wheel_too_large
);

  logic [2:0]  prime_count;
  logic [7:0]  prime [wnco_pkg::PrimeSlots];
  logic [2:0]  active;
  logic [2:0]  slot;
  logic [13:0] wsize;
  logic [12:0] k;
  logic [12:0] prev;
  logic [11:0] idx;
  logic [12:0] gap_count;
  logic [7:0]  res_cnt [wnco_pkg::PrimeSlots];
  logic [12:0] gap_table [wnco_pkg::MaxWheel];
  logic [63:0] value;
  logic [6:0]  bitpos;
  logic [12:0] rmd;
  logic [12:0] rem;
  logic [11:0] walk_i;
  logic [12:0] rd_data;
  logic        coprime;
  logic [13:0] rmd_sh;
  logic [21:0] prod;
  logic [11:0] rd_addr;

  assign active = (prime_count > 3'(wnco_pkg::PrimeSlots)) ?
                  3'(wnco_pkg::PrimeSlots) : prime_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_count <= 3'd4;
      prime[0] <= 8'd2; prime[1] <= 8'd3; prime[2] <= 8'd5; prime[3] <= 8'd7;
    end else if (cfg_we) begin
      if (cfg_idx == wnco_pkg::RegCount) prime_count <= cfg_data[2:0];
      else if (cfg_idx >= wnco_pkg::RegPrime0 && cfg_idx <= 3'(wnco_pkg::PrimeSlots))
        prime[2'(cfg_idx - wnco_pkg::RegPrime0)] <= cfg_data;
    end
  end

  // product of one slot per cycle, saturating past the bound
  assign prod = 22'(wsize) * 22'(prime[slot[1:0]]);
  assign stat.size_done = (slot >= active);
  assign stat.too_large = (wsize > 14'(wnco_pkg::MaxWheel));

  // coprime test via per-slot residue counters
  always_comb begin
    coprime = 1'b1;
    for (int s = 0; s < wnco_pkg::PrimeSlots; s++)
      if (3'(s) < active && prime[s] >= 8'd2 && res_cnt[s] == 8'd0) coprime = 1'b0;
  end
  assign stat.scan_done = (14'(k) >= wsize);

  always_ff @(posedge clk) begin
    if (ctrl.size_init) begin
      wsize <= 14'd1;
      slot  <= 3'd0;
    end else if (ctrl.size_step) begin
      if (prime[slot[1:0]] >= 8'd2)
        wsize <= (prod > 22'(wnco_pkg::MaxWheel)) ? 14'(wnco_pkg::MaxWheel + 1) : prod[13:0];
      slot <= slot + 3'd1;
    end
    if (ctrl.scan_init) begin
      k    <= 13'd2;
      prev <= 13'd1;
      idx  <= 12'd0;
      for (int s = 0; s < wnco_pkg::PrimeSlots; s++)
        res_cnt[s] <= (prime[s] == 8'd2) ? 8'd0 : 8'd2;
    end else if (ctrl.scan_step) begin
      if (coprime && idx < 12'(wnco_pkg::MaxWheel - 1)) begin
        idx  <= idx + 12'd1;
        prev <= k;
      end
      k <= k + 13'd1;
      for (int s = 0; s < wnco_pkg::PrimeSlots; s++)
        res_cnt[s] <= (res_cnt[s] + 8'd1 == prime[s]) ? 8'd0 : res_cnt[s] + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) gap_count <= 13'd0;
    else if (ctrl.size_init) gap_count <= 13'd0;
    else if (ctrl.scan_last) gap_count <= 13'(idx) + 13'd1;
  end

  // one-port table: build writes, walk reads with registered data
  assign rd_addr = walk_i - 12'd1;
  always_ff @(posedge clk) begin
    if (ctrl.scan_step && coprime && idx < 12'(wnco_pkg::MaxWheel - 1))
      gap_table[idx] <= k - prev;
    else if (ctrl.scan_last)
      gap_table[idx] <= wsize[12:0] + 13'd1 - prev;
    rd_data <= gap_table[rd_addr];
  end

  // restoring modulo, one bit per cycle
  assign rmd_sh = {rmd, value[63]};
  assign stat.mod_done = (bitpos == 7'd64);
  assign stat.direct = (rmd <= 13'd1);
  assign stat.walk_hit = (rem <= rd_data);
  assign stat.walk_end = (13'(walk_i) >= gap_count);

  always_ff @(posedge clk) begin
    if (ctrl.load_value) value <= start_value;
    if (ctrl.mod_init) begin
      rmd    <= 13'd0;
      bitpos <= 7'd0;
    end else if (ctrl.mod_step) begin
      rmd    <= (rmd_sh >= wsize) ? 13'(rmd_sh - wsize) : rmd_sh[12:0];
      value  <= {value[62:0], 1'b0};
      bitpos <= bitpos + 7'd1;
    end
    if (ctrl.walk_init) begin
      rem    <= rmd - 13'd1;
      walk_i <= 12'd1;
    end else if (ctrl.walk_step) begin
      rem    <= rem - rd_data;
      walk_i <= walk_i + 12'd1;
    end
  end

  // result fields, chosen on the finish command
  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      wheel_too_large <= 1'b0;
      distance        <= 13'd0;
      gap_index       <= 12'd0;
      if (stat.too_large || gap_count == 13'd0) begin
        wheel_too_large <= 1'b1;
      end else if (stat.direct) begin
        distance <= 13'd1 - rmd;
      end else if (stat.walk_hit) begin
        distance  <= rd_data - rem;
        gap_index <= stat.walk_end ? 12'd0 : walk_i;
      end
    end
  end

  logic unused;
  assign unused = ctrl.walk_read;

endmodule

FILE: src/wnco_ctrl.sv
// Controller state machine for the wheel offset block.
// Depends on wnco_pkg.
module wnco_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            cfg_we,
  input  wnco_pkg::stat_t stat,
  output wnco_pkg::ctrl_t ctrl,
  output logic            busy,
  output logic            done
);

  wnco_pkg::state_t state, state_next;
  logic stale;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wnco_pkg::ST_IDLE;
      stale <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_we) stale <= 1'b1;
      else if (state == wnco_pkg::ST_SIZE) stale <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wnco_pkg::ST_IDLE:
        if (start) state_next = stale ? wnco_pkg::ST_SIZE : wnco_pkg::ST_MOD;
      wnco_pkg::ST_SIZE:
        if (stat.size_done)
          state_next = stat.too_large ? wnco_pkg::ST_DONE : wnco_pkg::ST_SCAN_INIT;
      wnco_pkg::ST_SCAN_INIT: state_next = wnco_pkg::ST_SCAN;
      wnco_pkg::ST_SCAN: if (stat.scan_done) state_next = wnco_pkg::ST_SCAN_LAST;
      wnco_pkg::ST_SCAN_LAST: state_next = wnco_pkg::ST_MOD;
      wnco_pkg::ST_MOD:
        if (stat.mod_done)
          state_next = stat.direct ? wnco_pkg::ST_DONE : wnco_pkg::ST_WALK_WAIT;
      wnco_pkg::ST_WALK_WAIT: state_next = wnco_pkg::ST_WALK;
      wnco_pkg::ST_WALK:
        if (stat.walk_hit || stat.walk_end) state_next = wnco_pkg::ST_DONE;
        else state_next = wnco_pkg::ST_WALK_WAIT;
      wnco_pkg::ST_DONE: state_next = wnco_pkg::ST_IDLE;
      default: state_next = wnco_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      wnco_pkg::ST_IDLE: begin
        ctrl.load_value = start;
        ctrl.size_init  = start && stale;
        ctrl.mod_init   = start;
      end
      wnco_pkg::ST_SIZE:      ctrl.size_step = !stat.size_done;
      wnco_pkg::ST_SCAN_INIT: ctrl.scan_init = 1'b1;
      wnco_pkg::ST_SCAN:      ctrl.scan_step = !stat.scan_done;
      wnco_pkg::ST_SCAN_LAST: ctrl.scan_last = 1'b1;
      wnco_pkg::ST_MOD: begin
        ctrl.mod_step  = !stat.mod_done;
        ctrl.walk_init = stat.mod_done;
        ctrl.finish    = stat.mod_done && stat.direct;
      end
      wnco_pkg::ST_WALK_WAIT: ctrl.walk_read = 1'b1;
      wnco_pkg::ST_WALK: begin
        ctrl.finish    = stat.walk_hit || stat.walk_end;
        ctrl.walk_step = !(stat.walk_hit || stat.walk_end);
      end
      wnco_pkg::ST_DONE:      ctrl.finish = 1'b0;
      default: ctrl = '0;
    endcase
    // too-large exits straight from the size pass
    if (state == wnco_pkg::ST_SIZE && stat.size_done && stat.too_large) ctrl.finish = 1'b1;
  end

  assign busy = (state != wnco_pkg::ST_IDLE);
  assign done = (state == wnco_pkg::ST_DONE);

endmodule
